// ===== hw/rtl/population_std_deviation_macros.svh =====
// Assertion macros used by the population standard deviation controller.
`ifndef POPULATION_STD_DEVIATION_MACROS_SVH
`define POPULATION_STD_DEVIATION_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define POPSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define POPSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/popsd_pkg.sv =====
// Package: constants, payload structs and command struct for the std deviation block.
package popsd_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int FRAC_BITS   = 8;
  localparam int SAMPLE_BITS = 16;

  // Port field widths
  localparam int SAMPLE_W = 16;
  localparam int STD_W    = 24;
  localparam int COUNT_W  = 13;

  // Accumulator widths
  localparam int SUM_W   = 28;
  localparam int SUMSQ_W = 43;
  localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
  localparam int MAG_W   = SUM_W;

  // Final math widths
  localparam int SQLO_W  = 22;
  localparam int SQHI_W  = SUMSQ_W - SQLO_W;
  localparam int PLO_W   = COUNT_W + SQLO_W;
  localparam int PHI_W   = COUNT_W + SQHI_W;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int RAD_W   = PROD_W + 2 * FRAC_BITS;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int DREM_W  = COUNT_W;
  localparam int ITER_W  = $clog2(ROOT_W);
  localparam int STEPS   = ROOT_W;

  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(MAX_SAMPLES);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } item_t;

  typedef struct packed {
    logic [STD_W-1:0]   std_dev;
    logic [COUNT_W-1:0] sample_count;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic accumulate;
    logic load_abs;
    logic load_mul;
    logic load_sum;
    logic load_rad;
    logic sqrt_step;
    logic div_step;
    logic emit;
  } cmd_t;

endpackage

// ===== hw/rtl/popsd_dp.sv =====
// Datapath: accumulators, products, iterative square root and divider, result register.
module popsd_dp (
  input  logic               clk,
  input  logic               rst,
  input  popsd_pkg::cmd_t    cmd,
  input  popsd_pkg::item_t   item,
  output popsd_pkg::result_t result
);

  logic [popsd_pkg::COUNT_W-1:0]      count;
  logic signed [popsd_pkg::SUM_W-1:0] running_sum;
  logic [popsd_pkg::SUMSQ_W-1:0]      running_sum_sq;
  logic                               overflowed;

  logic [popsd_pkg::MAG_W-1:0]  s_mag;
  logic [popsd_pkg::PLO_W-1:0]  p_lo;
  logic [popsd_pkg::PHI_W-1:0]  p_hi;
  logic [popsd_pkg::PROD_W-1:0] sq;
  logic [popsd_pkg::PROD_W-1:0] prod;
  logic [popsd_pkg::RAD_W-1:0]  rad;
  logic [popsd_pkg::REM_W-1:0]  rem;
  logic [popsd_pkg::ROOT_W-1:0] root;
  logic [popsd_pkg::DREM_W-1:0] drem;

  logic signed [2*popsd_pkg::SAMPLE_W-1:0] sample_sq;
  logic [popsd_pkg::REM_W-1:0]    rem_sh;
  logic [popsd_pkg::REM_W-1:0]    trial;
  logic                           sqrt_ge;
  logic [popsd_pkg::DREM_W:0]     drem_sh;
  logic [popsd_pkg::DREM_W:0]     divisor;
  logic                           div_ge;
  logic [popsd_pkg::STD_W-1:0]    std_next;

  // Square the incoming sample
  assign sample_sq = item.sample * item.sample;

  // One digit of the square root per step
  always_comb begin
    rem_sh  = {rem[popsd_pkg::REM_W-3:0], rad[popsd_pkg::RAD_W-1 -: 2]};
    trial   = {root, 2'b01};
    sqrt_ge = (rem_sh >= trial);
  end

  // One quotient bit per step, root shifts out as dividend
  always_comb begin
    drem_sh = {drem, root[popsd_pkg::ROOT_W-1]};
    divisor = {1'b0, count};
    div_ge  = (drem_sh >= divisor);
  end

  // Saturate the quotient; an empty count gives zero
  always_comb begin
    if (count == '0) begin
      std_next = '0;
    end else if (|root[popsd_pkg::ROOT_W-1:popsd_pkg::STD_W]) begin
      std_next = '1;
    end else begin
      std_next = root[popsd_pkg::STD_W-1:0];
    end
  end

  // Accumulate samples until the count is full, clear as the result is loaded
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      count          <= '0;
      running_sum    <= '0;
      running_sum_sq <= '0;
      overflowed     <= 1'b0;
    end else if (cmd.accumulate) begin
      if (count == popsd_pkg::COUNT_FULL) begin
        overflowed <= 1'b1;
      end else begin
        count          <= count + 1'b1;
        running_sum    <= running_sum + popsd_pkg::SUM_W'(item.sample);
        running_sum_sq <= running_sum_sq
                          + popsd_pkg::SUMSQ_W'(sample_sq[popsd_pkg::SQ_W-1:0]);
      end
    end
  end

  // Final computation registers
  always_ff @(posedge clk) begin
    if (cmd.load_abs) begin
      s_mag <= running_sum[popsd_pkg::SUM_W-1] ? popsd_pkg::MAG_W'(-running_sum)
                                               : popsd_pkg::MAG_W'(running_sum);
      p_lo  <= popsd_pkg::PLO_W'(count)
               * popsd_pkg::PLO_W'(running_sum_sq[popsd_pkg::SQLO_W-1:0]);
    end
    if (cmd.load_mul) begin
      sq   <= popsd_pkg::PROD_W'(s_mag) * popsd_pkg::PROD_W'(s_mag);
      p_hi <= popsd_pkg::PHI_W'(count)
              * popsd_pkg::PHI_W'(running_sum_sq[popsd_pkg::SUMSQ_W-1:popsd_pkg::SQLO_W]);
    end
    if (cmd.load_sum) begin
      prod <= popsd_pkg::PROD_W'({p_hi, {popsd_pkg::SQLO_W{1'b0}}})
              + popsd_pkg::PROD_W'(p_lo);
    end
    if (cmd.load_rad) begin
      rad  <= {prod - sq, {(2*popsd_pkg::FRAC_BITS){1'b0}}};
      rem  <= '0;
      root <= '0;
      drem <= '0;
    end else if (cmd.sqrt_step) begin
      rad  <= {rad[popsd_pkg::RAD_W-3:0], 2'b00};
      rem  <= sqrt_ge ? (rem_sh - trial) : rem_sh;
      root <= {root[popsd_pkg::ROOT_W-2:0], sqrt_ge};
    end else if (cmd.div_step) begin
      drem <= div_ge ? popsd_pkg::DREM_W'(drem_sh - divisor)
                     : drem_sh[popsd_pkg::DREM_W-1:0];
      root <= {root[popsd_pkg::ROOT_W-2:0], div_ge};
    end
  end

  // Hold the result for the output transfer
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.std_dev      <= std_next;
      result.sample_count <= count;
      result.overflow     <= overflowed;
    end
  end

endmodule

// ===== hw/rtl/popsd_ctrl.sv =====
// Controller: sequences accumulation, final products, square root, divide and output.
`include "population_std_deviation_macros.svh"

module popsd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_last,
  output logic             item_ready,
  output logic             result_valid,
  input  logic             result_ready,
  output popsd_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_MUL,
    ST_ADD,
    ST_SUB,
    ST_SQRT,
    ST_DIV,
    ST_EMIT
  } state_t;

  localparam logic [popsd_pkg::ITER_W-1:0] LAST_ITER =
    popsd_pkg::ITER_W'(popsd_pkg::STEPS - 1);

  state_t                       state;
  logic [popsd_pkg::ITER_W-1:0] iter;
  logic                         item_xfer;
  logic                         out_free;

  assign item_ready = (state == ST_IDLE);
  assign item_xfer  = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  // Decode commands from state
  always_comb begin
    cmd            = '0;
    cmd.accumulate = item_xfer;
    cmd.load_abs   = (state == ST_ABS);
    cmd.load_mul   = (state == ST_MUL);
    cmd.load_sum   = (state == ST_ADD);
    cmd.load_rad   = (state == ST_SUB);
    cmd.sqrt_step  = (state == ST_SQRT);
    cmd.div_step   = (state == ST_DIV);
    cmd.emit       = (state == ST_EMIT) && out_free;
  end

  // Advance state, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      iter         <= '0;
      result_valid <= 1'b0;
    end else begin
      // Raise valid when the result loads, drop it after its transfer
      if (state == ST_EMIT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_xfer && item_last) begin
            state <= ST_ABS;
          end
        end
        ST_ABS: state <= ST_MUL;
        ST_MUL: state <= ST_ADD;
        ST_ADD: state <= ST_SUB;
        ST_SUB: begin
          iter  <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (iter == LAST_ITER) begin
            iter  <= '0;
            state <= ST_DIV;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        ST_DIV: begin
          if (iter == LAST_ITER) begin
            iter  <= '0;
            state <= ST_EMIT;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `POPSD_ASSERT_NEXT(a_last_starts_calc, item_xfer && item_last, state == ST_ABS,
                     "last sample did not start the final computation")
  `POPSD_ASSERT_NOW(a_iter_bound, state == ST_SQRT || state == ST_DIV, iter <= LAST_ITER,
                    "step counter ran past the digit count")
  `POPSD_ASSERT_NEXT(a_sqrt_to_div, state == ST_SQRT && iter == LAST_ITER,
                     state == ST_DIV && iter == '0,
                     "square root did not hand over to the divider")
  `POPSD_ASSERT_NOW(a_valid_from_emit, $rose(result_valid), $past(state) == ST_EMIT,
                    "result appeared outside the emit step")

endmodule

// ===== hw/rtl/population_std_deviation.sv =====
// Top level: population standard deviation over a run of signed samples.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------
//  item     | item_valid / item_ready     | sample (s16), last
//  result   | result_valid / result_ready | std_dev (u24, 8 frac), sample_count, overflow
//
// Samples that are not marked last are taken back to back.
// After the last sample the block forms the products and their difference
// (ABS, MUL, ADD, SUB), runs the 36-digit square root (one digit a cycle),
// divides by the count (one quotient bit a cycle) and loads the result
// register before the result is offered; item_ready is low meanwhile.
// A stalled result holds the block at the emit step until the output register frees.
// rst is synchronous and clears the accumulators, the sequencer and result_valid.
module population_std_deviation (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  popsd_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output popsd_pkg::result_t result
);

  popsd_pkg::cmd_t cmd;

  // Sequence the work
  popsd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_last    (item.last),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  // Do the arithmetic
  popsd_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result)
  );

endmodule

// ===== bench/popsd_checker.sv =====
// Scoreboard for the standard deviation block: tracks runs, predicts results, compares transfers.
module popsd_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  popsd_pkg::item_t   item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  popsd_pkg::result_t result,
  output int                 fail_count,
  output int                 pending_results,
  output int                 results_checked,
  output int                 overflow_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // Accumulators of the run in progress
  logic [popsd_pkg::COUNT_W-1:0]      run_count;
  logic signed [popsd_pkg::SUM_W-1:0] run_sum;
  logic [popsd_pkg::SUMSQ_W-1:0]      run_sum_sq;
  logic                               run_overflowed;

  popsd_pkg::result_t expected_results[$];

  // Floored deviation with FRAC_BITS fraction bits, from n, the sum and the sum of squares
  function automatic popsd_pkg::result_t deviation_of_run(
      input logic [popsd_pkg::COUNT_W-1:0]      n,
      input logic signed [popsd_pkg::SUM_W-1:0] s1,
      input logic [popsd_pkg::SUMSQ_W-1:0]      s2,
      input logic                               ovf);
    logic signed [127:0] sum_mag;
    logic [127:0]        radicand;
    logic [127:0]        root;
    logic [127:0]        place;
    logic [127:0]        trial;
    logic [127:0]        quotient;
    popsd_pkg::result_t  r;
    // Widen before negating: the sum may sit at the most negative 28-bit value
    sum_mag = s1;
    if (sum_mag < 0) sum_mag = -sum_mag;
    radicand = (128'(n) * 128'(s2) - unsigned'(sum_mag) * unsigned'(sum_mag))
               << (2 * popsd_pkg::FRAC_BITS);
    // Integer square root, two bits of radicand per step
    root  = '0;
    place = 128'd1 << 126;
    while (place > radicand) place = place >> 2;
    while (place != 0) begin
      trial = root + place;
      if (radicand >= trial) begin
        radicand = radicand - trial;
        root     = (root >> 1) + place;
      end else begin
        root = root >> 1;
      end
      place = place >> 2;
    end
    quotient = (n == 0) ? '0 : root / 128'(n);
    r.std_dev      = (quotient > 128'({popsd_pkg::STD_W{1'b1}})) ? {popsd_pkg::STD_W{1'b1}}
                                                                 : quotient[popsd_pkg::STD_W-1:0];
    r.sample_count = n;
    r.overflow     = ovf;
    return r;
  endfunction

  always @(posedge clk) begin : track
    logic signed [31:0] square;
    popsd_pkg::result_t want;
    if (rst) begin
      run_count        = '0;
      run_sum          = '0;
      run_sum_sq       = '0;
      run_overflowed   = 1'b0;
      fail_count       = 0;
      results_checked  = 0;
      overflow_results = 0;
      expected_results.delete();
    end else begin
      // Accumulate each sample transfer; refuse it once the count is full
      if (item_valid && item_ready) begin
        if (run_count < popsd_pkg::COUNT_FULL) begin
          square     = item.sample * item.sample;
          run_sum    = run_sum + item.sample;
          run_sum_sq = run_sum_sq + popsd_pkg::SUMSQ_W'(unsigned'(square));
          run_count  = run_count + 1'b1;
        end else begin
          run_overflowed = 1'b1;
        end
        // Close the run on the marked sample and clear for the next one
        if (item.last) begin
          expected_results.push_back(deviation_of_run(run_count, run_sum, run_sum_sq,
                                                      run_overflowed));
          run_count      = '0;
          run_sum        = '0;
          run_sum_sq     = '0;
          run_overflowed = 1'b0;
        end
      end
      // Compare each result transfer with the oldest prediction
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: std_dev %0d, sample_count %0d, overflow %0d",
                 result.std_dev, result.sample_count, result.overflow);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.overflow) overflow_results++;
          if (result.std_dev !== want.std_dev) begin
            $error("std_dev mismatch: expected %0d, actual %0d", want.std_dev, result.std_dev);
            fail_count++;
          end
          if (result.sample_count !== want.sample_count) begin
            $error("sample_count mismatch: expected %0d, actual %0d",
                   want.sample_count, result.sample_count);
            fail_count++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow mismatch: expected %0d, actual %0d", want.overflow,
                   result.overflow);
            fail_count++;
          end
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== bench/population_std_deviation_tb.sv =====
// Testbench top: drives sample runs and result stalls, gives the verdict.
module population_std_deviation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_SAMPLES = 1750;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 150;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_ready;
  popsd_pkg::item_t   item         = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  popsd_pkg::result_t result;

  int fail_count;
  int pending_results;
  int results_checked;
  int overflow_results;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int samples_sent  = 0;
  int runs_sent     = 0;
  int stall_cycles  = 0;

  always #5 clk = ~clk;

  population_std_deviation u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  popsd_checker u_chk (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .item             (item),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .result           (result),
    .fail_count       (fail_count),
    .pending_results  (pending_results),
    .results_checked  (results_checked),
    .overflow_results (overflow_results)
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run when neither channel has moved a transfer for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one sample, idling first at random, and hold it until the transfer
  task automatic push_sample(input logic signed [popsd_pkg::SAMPLE_W-1:0] value,
                             input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{sample: value, last: is_last};
    @(negedge clk);
    while (!item_ready) @(negedge clk);
    @(posedge clk);
    samples_sent++;
    if (is_last) runs_sent++;
  endtask

  // Send a whole run; style picks how the sample values spread
  task automatic push_run(input int length, input int style);
    logic signed [popsd_pkg::SAMPLE_W-1:0] base;
    logic signed [popsd_pkg::SAMPLE_W-1:0] value;
    base = popsd_pkg::SAMPLE_W'($urandom);
    for (int k = 0; k < length; k++) begin
      case (style)
        0: value = popsd_pkg::SAMPLE_W'($urandom);
        1: value = base + popsd_pkg::SAMPLE_W'($urandom_range(15));
        2: value = base;
        default: begin
          case ($urandom_range(3))
            0: value = {1'b1, {(popsd_pkg::SAMPLE_W-1){1'b0}}};
            1: value = {1'b0, {(popsd_pkg::SAMPLE_W-1){1'b1}}};
            2: value = '0;
            default: value = '1;
          endcase
        end
      endcase
      push_sample(value, k == length - 1);
    end
  endtask

  // Random runs, mostly short, some long, until the sample budget is spent
  task automatic push_random_runs(input int budget);
    int sent;
    int length;
    int pick;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 70) length = $urandom_range(1, 8);
      else if (pick < 95) length = $urandom_range(9, 64);
      else length = $urandom_range(65, 300);
      push_run(length, $urandom_range(3));
      sent += length;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 16;
    recv_idle_pct = 70;

    // Single-sample runs at the extremes: deviation is zero
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh0000, 1'b1);
    // Widest spread of two samples
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    // Alternating bit patterns
    push_sample(16'sh5555, 1'b0);
    push_sample(16'shaaaa, 1'b1);
    // Constant run
    repeat (2) push_sample(16'sd1234, 1'b0);
    push_sample(16'sd1234, 1'b1);
    // Small ramp and a symmetric pair
    for (int k = 1; k <= 4; k++) push_sample(16'(k), k == 4);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd1, 1'b1);

    push_random_runs(RANDOM_SAMPLES / 3);
    send_idle_pct = 70;
    recv_idle_pct = 16;
    push_random_runs(RANDOM_SAMPLES / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_runs(RANDOM_SAMPLES - 2 * (RANDOM_SAMPLES / 3));

    // Drain outstanding results, then watch for strays
    item_valid <= 1'b0;
    @(negedge clk);
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples in %0d runs: extreme, constant and random runs under stalls.",
             samples_sent, runs_sent);
    $display("Checked %0d results, %0d of them flagged overflow.", results_checked,
             overflow_results);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== population_std_deviation.f =====
+incdir+hw/rtl
hw/rtl/popsd_pkg.sv
hw/rtl/popsd_dp.sv
hw/rtl/popsd_ctrl.sv
hw/rtl/population_std_deviation.sv
bench/popsd_checker.sv
bench/population_std_deviation_tb.sv
